### hw/rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared sizes, codes and control bundles of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	// node pool and field sizes
	localparam int POOL_NODES = 64;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int CNT_W      = $clog2(POOL_NODES + 1);
	localparam int DATA_W     = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// node memory request: one write address shared by value and link
	typedef struct packed {
		logic                     wr_val;
		logic                     wr_link;
		logic [IDX_W-1:0]         wr_addr;
		logic signed [DATA_W-1:0] wr_value;
		logic [IDX_W-1:0]         wr_link_data;
		logic [IDX_W-1:0]         rd_addr;
	} mem_req_t;

	// free node tracker control
	typedef struct packed {
		logic             start;
		logic             set;
		logic [IDX_W-1:0] set_idx;
		logic             clr;
		logic [IDX_W-1:0] clr_idx;
	} scan_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/circular_list_engine_unit.sv
// ----------------------------------------------------------------------------
// circular_list_engine_unit
// Circular singly linked list in a node pool, walked one node per cycle.
// ----------------------------------------------------------------------------
// insert ends with the later of the walk and the free-node scan; delete reads
//   the tail, then walks; dump gives its first beat after reading the tail, then
//   one beat per cycle; empty, full and unused commands answer in the next cycle
// throughput: one command at a time; the walk does one node memory read a cycle
// result beats cannot be stalled; busy drops with the cycle of the last beat
// reset: list empty, all nodes free, tail and count zero
`default_nettype none

module circular_list_engine_unit
	import cle_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               command,
	input  wire logic signed [DATA_W-1:0] key,
	input  wire logic signed [DATA_W-1:0] new_value,
	output logic                          strobe,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      out_value,
	output logic                          last,
	output logic [CNT_W-1:0]              count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_WALK,
		S_INS_WAIT,
		S_INS_LINK,
		S_DEL_FIRST,
		S_DEL_WALK,
		S_DUMP
	} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         cur_q;
	logic [IDX_W-1:0]         prev_q;
	logic [IDX_W-1:0]         next_q;
	logic [IDX_W-1:0]         new_q;
	logic [CNT_W-1:0]         step_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] val_q;

	logic                     strobe_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     last_q;
	logic [CNT_W-1:0]         count_out_q;

	mem_req_t                 mreq;
	scan_ctl_t                sctl;
	logic signed [DATA_W-1:0] rd_value;
	logic [IDX_W-1:0]         rd_link;
	logic                     scan_found;
	logic [IDX_W-1:0]         free_idx;

	logic                     accept;
	logic                     hit;
	logic                     at_end;

	cle_node_mem u_mem (
		.clk      (clk),
		.req      (mreq),
		.rd_value (rd_value),
		.rd_link  (rd_link)
	);

	cle_free_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.found    (scan_found),
		.free_idx (free_idx)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// shared compare on the node just read, and walk end
	assign hit    = (rd_value == key_q);
	assign at_end = (step_q == count_q - CNT_W'(1));

	// memory and allocation requests
	always_comb begin
		mreq         = '0;
		mreq.rd_addr = cur_q;
		sctl         = '0;
		case (state_q)
			S_IDLE: begin
				mreq.rd_addr = tail_q;
				if (accept && command == CMD_INSERT) begin
					if (count_q == '0) begin
						mreq.wr_val       = 1'b1;
						mreq.wr_link      = 1'b1;
						mreq.wr_addr      = '0;
						mreq.wr_value     = new_value;
						mreq.wr_link_data = '0;
						sctl.set          = 1'b1;
						sctl.set_idx      = '0;
					end else if (count_q != CNT_W'(POOL_NODES)) begin
						sctl.start = 1'b1;
					end
				end
			end
			S_INS_WALK: begin
				if (!hit && !at_end) begin
					mreq.rd_addr = rd_link;
				end
			end
			S_INS_WAIT: begin
				if (scan_found) begin
					mreq.wr_val       = 1'b1;
					mreq.wr_link      = 1'b1;
					mreq.wr_addr      = free_idx;
					mreq.wr_value     = val_q;
					mreq.wr_link_data = next_q;
					sctl.set          = 1'b1;
					sctl.set_idx      = free_idx;
				end
			end
			S_INS_LINK: begin
				mreq.wr_link      = 1'b1;
				mreq.wr_addr      = cur_q;
				mreq.wr_link_data = new_q;
			end
			S_DEL_FIRST: begin
				mreq.rd_addr = rd_link;
			end
			S_DEL_WALK: begin
				if (hit) begin
					mreq.wr_link      = 1'b1;
					mreq.wr_addr      = prev_q;
					mreq.wr_link_data = rd_link;
					sctl.clr          = 1'b1;
					sctl.clr_idx      = cur_q;
				end else if (!at_end) begin
					mreq.rd_addr = rd_link;
				end
			end
			S_DUMP: begin
				if (!at_end) begin
					mreq.rd_addr = rd_link;
				end
			end
			default: begin
				mreq.rd_addr = cur_q;
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tail_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			next_q      <= '0;
			new_q       <= '0;
			step_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			strobe_q    <= 1'b0;
			status_q    <= ST_OK;
			out_value_q <= '0;
			last_q      <= 1'b0;
			count_out_q <= '0;
		end else begin
			strobe_q    <= 1'b0;
			out_value_q <= '0;
			last_q      <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q  <= key;
						val_q  <= new_value;
						cur_q  <= tail_q;
						step_q <= '0;
						case (command)
							CMD_INSERT: begin
								if (count_q == '0) begin
									tail_q      <= '0;
									count_q     <= CNT_W'(1);
									strobe_q    <= 1'b1;
									status_q    <= ST_OK;
									count_out_q <= CNT_W'(1);
								end else if (count_q == CNT_W'(POOL_NODES)) begin
									strobe_q    <= 1'b1;
									status_q    <= ST_FULL;
									count_out_q <= count_q;
								end else begin
									state_q <= S_INS_WALK;
								end
							end
							CMD_DELETE: begin
								if (count_q == '0) begin
									strobe_q    <= 1'b1;
									status_q    <= ST_EMPTY;
									count_out_q <= count_q;
								end else begin
									state_q <= S_DEL_FIRST;
								end
							end
							CMD_DUMP: begin
								if (count_q == '0) begin
									strobe_q    <= 1'b1;
									status_q    <= ST_EMPTY;
									count_out_q <= count_q;
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								strobe_q    <= 1'b1;
								status_q    <= ST_OK;
								count_out_q <= count_q;
							end
						endcase
					end
				end
				S_INS_WALK: begin
					if (hit) begin
						next_q  <= rd_link;
						state_q <= S_INS_WAIT;
					end else if (at_end) begin
						strobe_q    <= 1'b1;
						status_q    <= ST_NOT_FOUND;
						count_out_q <= count_q;
						state_q     <= S_IDLE;
					end else begin
						cur_q  <= rd_link;
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_INS_WAIT: begin
					if (scan_found) begin
						new_q   <= free_idx;
						state_q <= S_INS_LINK;
					end
				end
				S_INS_LINK: begin
					count_q     <= count_q + CNT_W'(1);
					strobe_q    <= 1'b1;
					status_q    <= ST_OK;
					count_out_q <= count_q + CNT_W'(1);
					state_q     <= S_IDLE;
				end
				S_DEL_FIRST: begin
					prev_q  <= tail_q;
					cur_q   <= rd_link;
					state_q <= S_DEL_WALK;
				end
				S_DEL_WALK: begin
					if (hit) begin
						strobe_q <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
						if (prev_q == cur_q || count_q == CNT_W'(1)) begin
							count_q     <= '0;
							tail_q      <= '0;
							count_out_q <= '0;
						end else begin
							count_q     <= count_q - CNT_W'(1);
							count_out_q <= count_q - CNT_W'(1);
							if (cur_q == tail_q) begin
								tail_q <= prev_q;
							end
						end
					end else if (at_end) begin
						strobe_q    <= 1'b1;
						status_q    <= ST_NOT_FOUND;
						count_out_q <= count_q;
						state_q     <= S_IDLE;
					end else begin
						prev_q <= cur_q;
						cur_q  <= rd_link;
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_DUMP: begin
					strobe_q    <= 1'b1;
					status_q    <= ST_OK;
					out_value_q <= rd_value;
					last_q      <= at_end;
					count_out_q <= count_q;
					if (at_end) begin
						state_q <= S_IDLE;
					end else begin
						cur_q  <= rd_link;
						step_q <= step_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	assign last      = last_q;
	assign count     = count_out_q;

endmodule

`default_nettype wire

### hw/rtl/cle_node_mem.sv
// ----------------------------------------------------------------------------
// cle_node_mem
// Node value and next-link memories, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_node_mem
	import cle_pkg::*;
(
	input  wire logic                     clk,
	input  wire mem_req_t                 req,
	output logic signed [DATA_W-1:0]      rd_value,
	output logic [IDX_W-1:0]              rd_link
);

	logic signed [DATA_W-1:0] value_mem [POOL_NODES];
	logic [IDX_W-1:0]         link_mem  [POOL_NODES];

	// value store
	always_ff @(posedge clk) begin
		if (req.wr_val) begin
			value_mem[req.wr_addr] <= req.wr_value;
		end
		rd_value <= value_mem[req.rd_addr];
	end

	// link store
	always_ff @(posedge clk) begin
		if (req.wr_link) begin
			link_mem[req.wr_addr] <= req.wr_link_data;
		end
		rd_link <= link_mem[req.rd_addr];
	end

endmodule

`default_nettype wire

### hw/rtl/cle_free_scan.sv
// ----------------------------------------------------------------------------
// cle_free_scan
// Node allocation flags and a one-entry-per-cycle scan for the lowest free node.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_free_scan
	import cle_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_ctl_t        ctl,
	output logic                  found,
	output logic [IDX_W-1:0]      free_idx
);

	logic [POOL_NODES-1:0] used_q;
	logic [IDX_W-1:0]      scan_q;
	logic                  run_q;

	// allocation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (ctl.set) begin
				used_q[ctl.set_idx] <= 1'b1;
			end
			if (ctl.clr) begin
				used_q[ctl.clr_idx] <= 1'b0;
			end
		end
	end

	// scan upward from entry zero until a free flag is seen or the last entry is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			run_q  <= 1'b0;
		end else if (ctl.start) begin
			scan_q <= '0;
			run_q  <= 1'b1;
		end else if (run_q) begin
			if (!used_q[scan_q] || scan_q == IDX_W'(POOL_NODES - 1)) begin
				run_q <= 1'b0;
			end else begin
				scan_q <= scan_q + IDX_W'(1);
			end
		end
	end

	assign found    = !run_q;
	assign free_idx = scan_q;

endmodule

`default_nettype wire
